// ----- hdl/pdpf_pkg.sv -----
package pdpf_pkg;

   // field widths fixed by the payload format
   localparam int COORD_W   = 24;
   localparam int THR_W     = 52;
   localparam int IDX_OUT_W = 6;

   // distance datapath
   localparam int DIFF_W = COORD_W + 1;
   localparam int SQ_W   = 2 * DIFF_W;
   localparam int SUM_W  = SQ_W + 2;
   localparam int CMP_W  = (SUM_W > THR_W) ? SUM_W : THR_W;

   localparam int POINT_CAPACITY_DEF = 64;

   // command queue between front and back (power of two)
   localparam int CMD_DEPTH = 2;
   localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
   localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

   // result queue (power of two)
   localparam int RSP_DEPTH = 8;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   typedef struct packed {
      logic signed [COORD_W-1:0] coord_x;
      logic signed [COORD_W-1:0] coord_y;
      logic signed [COORD_W-1:0] coord_z;
   } pdpf_point_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] coord_x;
      logic signed [COORD_W-1:0] coord_y;
      logic signed [COORD_W-1:0] coord_z;
      logic                      restart;
   } pdpf_req_type;

   typedef struct packed {
      logic [IDX_OUT_W-1:0] earlier_index;
      logic [IDX_OUT_W-1:0] newer_index;
      logic                 last_match;
   } pdpf_rsp_type;

   typedef struct packed {
      logic                 empty;
      logic [RSP_CNT_W-1:0] free;
   } pdpf_rsp_stat_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SCAN,
      BK_FLUSH
   } pdpf_back_state_type;

endpackage

// ----- hdl/point_duplicate_pair_finder.sv -----
// Near-duplicate pair finder for a stream of 3D points. Each accepted point
// (signed coordinates, 8 fractional bits) gets the next index in arrival
// order and is compared against every stored point, oldest first; a pair
// whose squared distance is strictly below threshold_squared yields one
// result beat {earlier_index, newer_index, last_match}, last_match set on
// the point's final match. restart empties the set first, so that point
// gets index 0 and no results. Once POINT_CAPACITY points are stored,
// further points are dropped silently. The scan engine reads one stored
// point per cycle from a single-read-port point memory while the result
// queue has room, then drains a short pipeline and makes the store write.
// A two-beat command queue lets new points be taken while a scan runs;
// the scan pauses when the result queue has no room for every comparison
// in flight.
module point_duplicate_pair_finder
   import pdpf_pkg::*;
#(
   parameter int POINT_CAPACITY = POINT_CAPACITY_DEF
) (
   input  logic               clock,
   input  logic               reset,
   // point beats
   input  logic               req_push,
   output logic               req_full,
   input  pdpf_req_type       req_data,
   // result beats
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output pdpf_rsp_type       rsp_data,
   // threshold register
   input  logic               csr_wr_en,
   input  logic [THR_W-1:0]   csr_wr_data
);

   localparam int IDX_W = $clog2(POINT_CAPACITY);

   // front -> back commands: classified point plus its index
   logic              cmd_empty;
   logic              cmd_pop;
   pdpf_point_type    cmd_point;
   logic [IDX_W-1:0]  cmd_index;

   // back -> result queue
   logic              rsp_push;
   pdpf_rsp_type      rsp_wdata;
   pdpf_rsp_stat_type rsp_stat;

   // front: accepts beats, handles restart and the full set, numbers points
   pdpf_front #(
      .POINT_CAPACITY(POINT_CAPACITY),
      .IDX_W         (IDX_W)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .cmd_empty(cmd_empty),
      .cmd_pop  (cmd_pop),
      .cmd_point(cmd_point),
      .cmd_index(cmd_index)
   );

   // back: point memory, distance pipeline, match ordering and last flag
   pdpf_back #(
      .POINT_CAPACITY(POINT_CAPACITY),
      .IDX_W         (IDX_W)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .cmd_empty  (cmd_empty),
      .cmd_pop    (cmd_pop),
      .cmd_point  (cmd_point),
      .cmd_index  (cmd_index),
      .rsp_stat   (rsp_stat),
      .rsp_push   (rsp_push),
      .rsp_wdata  (rsp_wdata)
   );

   // result queue decouples the scan from the consumer
   pdpf_rsp_fifo u_rsp_fifo (
      .clock(clock),
      .reset(reset),
      .push (rsp_push),
      .wdata(rsp_wdata),
      .pop  (rsp_pop),
      .rdata(rsp_data),
      .stat (rsp_stat)
   );

   assign rsp_empty = rsp_stat.empty;

   // credit check in the back must keep the result queue from overflowing
   a_rsp_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(rsp_push && (rsp_stat.free == '0)))
      else $error("result queue overflow");

   // back only takes a command that the front holds
   a_cmd_pop_valid: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> !cmd_empty)
      else $error("command taken from empty queue");

   // both queues come out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (rsp_empty && cmd_empty && !req_full))
      else $error("queues not empty after reset");

endmodule

// ----- hdl/pdpf_front.sv -----
module pdpf_front
   import pdpf_pkg::*;
#(
   parameter int POINT_CAPACITY = POINT_CAPACITY_DEF,
   parameter int IDX_W          = $clog2(POINT_CAPACITY)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  pdpf_req_type       req_data,
   output logic               cmd_empty,
   input  logic               cmd_pop,
   output pdpf_point_type     cmd_point,
   output logic [IDX_W-1:0]   cmd_index
);

   localparam int CNT_W = $clog2(POINT_CAPACITY + 1);
   localparam logic [CNT_W-1:0] CAP = CNT_W'(POINT_CAPACITY);

   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     base;
   logic                 accept, enq;
   pdpf_point_type       pt_ff [CMD_DEPTH];
   logic [IDX_W-1:0]     idx_ff [CMD_DEPTH];
   logic [CMD_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CMD_CNT_W-1:0] used_ff, used_in;
   logic                 deq;

   assign req_full  = (used_ff == CMD_CNT_W'(CMD_DEPTH));
   assign cmd_empty = (used_ff == '0);
   assign accept    = req_push && !req_full;
   assign deq       = cmd_pop && !cmd_empty;

   // restart numbers the point from zero; a full set drops it
   assign base = req_data.restart ? '0 : count_ff;
   assign enq  = accept && (base < CAP);

   always_comb begin
      count_in = count_ff;
      if (enq) begin
         count_in = base + CNT_W'(1);
      end
      used_in = used_ff;
      unique case ({enq, deq})
         2'b10:   used_in = used_ff + CMD_CNT_W'(1);
         2'b01:   used_in = used_ff - CMD_CNT_W'(1);
         default: used_in = used_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         used_ff   <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         count_ff <= count_in;
         used_ff  <= used_in;
         if (enq) begin
            wr_ptr_ff <= wr_ptr_ff + CMD_PTR_W'(1);
         end
         if (deq) begin
            rd_ptr_ff <= rd_ptr_ff + CMD_PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enq) begin
         pt_ff[wr_ptr_ff]  <= '{coord_x: req_data.coord_x,
                               coord_y: req_data.coord_y,
                               coord_z: req_data.coord_z};
         idx_ff[wr_ptr_ff] <= base[IDX_W-1:0];
      end
   end

   assign cmd_point = pt_ff[rd_ptr_ff];
   assign cmd_index = idx_ff[rd_ptr_ff];

endmodule

// ----- hdl/pdpf_back.sv -----
module pdpf_back
   import pdpf_pkg::*;
#(
   parameter int POINT_CAPACITY = POINT_CAPACITY_DEF,
   parameter int IDX_W          = $clog2(POINT_CAPACITY)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [THR_W-1:0]   csr_wr_data,
   input  logic               cmd_empty,
   output logic               cmd_pop,
   input  pdpf_point_type     cmd_point,
   input  logic [IDX_W-1:0]   cmd_index,
   input  pdpf_rsp_stat_type  rsp_stat,
   output logic               rsp_push,
   output pdpf_rsp_type       rsp_wdata
);

   localparam int WIDE_W = IDX_W + IDX_OUT_W;

   pdpf_back_state_type state_ff, state_in;

   logic [THR_W-1:0]   thresh_ff;
   pdpf_point_type     pt_ff;
   logic [IDX_W-1:0]   idx_ff;
   logic [IDX_W-1:0]   j_ff;
   logic               load, issue, store;

   pdpf_point_type     mem_ff [POINT_CAPACITY];
   pdpf_point_type     rd_data_ff;

   logic               rd_v_ff, d_v_ff, q_v_ff;
   logic [IDX_W-1:0]   rd_j_ff, d_j_ff, q_j_ff;
   logic [DIFF_W-1:0]  dx_ff, dy_ff, dz_ff;
   logic [DIFF_W-1:0]  dx_in, dy_in, dz_in;
   logic [SQ_W-1:0]    qx_ff, qy_ff, qz_ff;
   logic [SUM_W-1:0]   sum;
   logic               match;
   logic [RSP_CNT_W-1:0] inflight;
   logic               credit;

   logic               pend_v_ff, pend_v_in;
   logic [IDX_OUT_W-1:0] pend_e_ff;
   logic [WIDE_W-1:0]  newer_wide, q_j_wide;
   logic [IDX_OUT_W-1:0] newer6;

   function automatic logic [DIFF_W-1:0] abs_diff(logic signed [COORD_W-1:0] a,
                                                  logic signed [COORD_W-1:0] b);
      logic [DIFF_W-1:0] d;
      d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
      return d[DIFF_W-1] ? (~d + DIFF_W'(1)) : d;
   endfunction

   assign newer_wide = WIDE_W'(idx_ff);
   assign newer6     = newer_wide[IDX_OUT_W-1:0];
   assign q_j_wide   = WIDE_W'(q_j_ff);

   // every read in flight may push one result; never overrun the queue
   assign inflight = RSP_CNT_W'(rd_v_ff) + RSP_CNT_W'(d_v_ff) + RSP_CNT_W'(q_v_ff);
   assign credit   = rsp_stat.free > inflight;

   assign sum   = SUM_W'(qx_ff) + SUM_W'(qy_ff) + SUM_W'(qz_ff);
   assign match = q_v_ff && (CMP_W'(sum) < CMP_W'(thresh_ff));

   assign dx_in = abs_diff(pt_ff.coord_x, rd_data_ff.coord_x);
   assign dy_in = abs_diff(pt_ff.coord_y, rd_data_ff.coord_y);
   assign dz_in = abs_diff(pt_ff.coord_z, rd_data_ff.coord_z);

   always_comb begin
      state_in  = state_ff;
      cmd_pop   = 1'b0;
      load      = 1'b0;
      issue     = 1'b0;
      store     = 1'b0;
      pend_v_in = pend_v_ff;
      rsp_push  = 1'b0;
      rsp_wdata = '{earlier_index: pend_e_ff, newer_index: newer6, last_match: 1'b0};
      unique case (state_ff)
         BK_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop  = 1'b1;
               load     = 1'b1;
               state_in = BK_SCAN;
            end
         end
         BK_SCAN: begin
            issue = (j_ff != idx_ff) && credit;
            // a new match releases the one held back
            if (match) begin
               rsp_push  = pend_v_ff;
               pend_v_in = 1'b1;
            end
            if ((j_ff == idx_ff) && !rd_v_ff && !d_v_ff && !q_v_ff) begin
               state_in = BK_FLUSH;
            end
         end
         BK_FLUSH: begin
            if (!pend_v_ff || (rsp_stat.free != '0)) begin
               rsp_push             = pend_v_ff;
               rsp_wdata.last_match = 1'b1;
               pend_v_in            = 1'b0;
               store                = 1'b1;
               state_in             = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= BK_IDLE;
         thresh_ff <= '0;
         pend_v_ff <= 1'b0;
         rd_v_ff   <= 1'b0;
         d_v_ff    <= 1'b0;
         q_v_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         pend_v_ff <= pend_v_in;
         rd_v_ff   <= issue;
         d_v_ff    <= rd_v_ff;
         q_v_ff    <= d_v_ff;
         if (csr_wr_en) begin
            thresh_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pt_ff  <= cmd_point;
         idx_ff <= cmd_index;
         j_ff   <= '0;
      end else if (issue) begin
         j_ff <= j_ff + IDX_W'(1);
      end
      if (match) begin
         pend_e_ff <= q_j_wide[IDX_OUT_W-1:0];
      end
      rd_j_ff <= j_ff;
      d_j_ff  <= rd_j_ff;
      q_j_ff  <= d_j_ff;
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      dz_ff   <= dz_in;
      qx_ff   <= dx_ff * dx_ff;
      qy_ff   <= dy_ff * dy_ff;
      qz_ff   <= dz_ff * dz_ff;
   end

   // point store: one read port for the scan, one write at the end of a point
   always_ff @(posedge clock) begin
      if (store) begin
         mem_ff[idx_ff] <= pt_ff;
      end
      rd_data_ff <= mem_ff[j_ff];
   end

endmodule

// ----- hdl/pdpf_rsp_fifo.sv -----
module pdpf_rsp_fifo
   import pdpf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  pdpf_rsp_type      wdata,
   input  logic              pop,
   output pdpf_rsp_type      rdata,
   output pdpf_rsp_stat_type stat
);

   pdpf_rsp_type         slot_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [RSP_CNT_W-1:0] used_ff;
   logic                 deq;

   assign stat.empty = (used_ff == '0);
   assign stat.free  = RSP_CNT_W'(RSP_DEPTH) - used_ff;
   assign deq        = pop && !stat.empty;
   assign rdata      = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff   <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         unique case ({push, deq})
            2'b10:   used_ff <= used_ff + RSP_CNT_W'(1);
            2'b01:   used_ff <= used_ff - RSP_CNT_W'(1);
            default: used_ff <= used_ff;
         endcase
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + RSP_PTR_W'(1);
         end
         if (deq) begin
            rd_ptr_ff <= rd_ptr_ff + RSP_PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule
